@@ hw/rtl/aesx_pkg.sv @@
// Shared types and constants for the ANSI escape sequence extractor.
// No dependencies; all other files but aesx_ram import this package.
`timescale 1ns / 1ps

package aesx_pkg;

  // Longest sequence kept in the capture store, ESC included
  localparam int MAX_SEQUENCE = 30;
  localparam int ADDR_W       = $clog2(MAX_SEQUENCE);
  localparam int CNT_W        = $clog2(MAX_SEQUENCE + 1);
  localparam int SEQ_LEN_W    = 5;
  localparam int FIFO_DEPTH   = 2;

  localparam logic [7:0] ESC_BYTE     = 8'h1B;
  localparam logic [7:0] CSI_BRACKET  = 8'h5B;  // '['
  localparam logic [7:0] LOWER_A      = 8'h61;  // 'a'
  localparam logic [7:0] LOWER_Z      = 8'h7A;  // 'z'
  localparam logic [7:0] UPPER_A      = 8'h41;  // 'A'
  localparam logic [7:0] UPPER_N      = 8'h4E;  // 'N'
  localparam logic [7:0] UPPER_P      = 8'h50;  // 'P'
  localparam logic [7:0] UPPER_Z      = 8'h5A;  // 'Z'

  typedef enum logic [1:0] {
    ST_CONTINUE = 2'd0,
    ST_EMIT     = 2'd1,
    ST_NOT_ESC  = 2'd2
  } status_t;

  // Command passed from the front end to the back end
  typedef struct packed {
    status_t          kind;
    logic [CNT_W-1:0] len;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FETCH,
    BK_LOAD
  } back_state_t;

endpackage

@@ hw/rtl/ansi_escape_sequence_extractor_unit.sv @@
// ANSI escape sequence extractor: one byte in, one or more results out.
// Uses aesx_pkg, aesx_front, aesx_cmd_fifo, aesx_back and aesx_ram.
//
// Input channel in_valid/in_ready/in_byte takes one character byte per
// transaction. Result channel out_valid/out_ready carries out_status,
// out_byte, out_seq_length and out_last. A byte outside a sequence yields
// one "not an escape" result; ESC and the bytes that keep a sequence open
// yield one "continue" result each. The byte that closes a sequence yields
// the whole stored sequence, one result per byte, out_last on the final one.
// A single result passes through the command queue and the result register.
// An emission does one store read plus one result load per byte; input is
// held off from the closing byte until the last byte of the emission is
// loaded, since a new sequence would overwrite the store. Outside
// emissions the block takes one byte per cycle while the two-entry command
// queue has room.
// When the receiver stalls, the result register holds and the queue fills,
// then in_ready drops. Synchronous reset returns the block to idle with
// empty queue and no result pending; the store needs no clearing.
`timescale 1ns / 1ps

module ansi_escape_sequence_extractor_unit import aesx_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_status,
  output logic [7:0]           out_byte,
  output logic [SEQ_LEN_W-1:0] out_seq_length,
  output logic                 out_last
);

  logic              push_valid, push_ready;
  cmd_t              push_cmd;
  logic              pop_valid, pop_ready;
  cmd_t              pop_cmd;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;
  logic              emit_done;

  aesx_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .emit_done  (emit_done)
  );

  aesx_cmd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  aesx_ram #(
    .WIDTH (8),
    .DEPTH (MAX_SEQUENCE)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  aesx_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .pop_cmd        (pop_cmd),
    .ram_re         (ram_re),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata),
    .emit_done      (emit_done),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_byte       (out_byte),
    .out_seq_length (out_seq_length),
    .out_last       (out_last)
  );

endmodule

@@ hw/rtl/aesx_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; width and depth come in as parameters.
`timescale 1ns / 1ps

module aesx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 30,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/aesx_front.sv @@
// Front end: accepts input bytes, tracks the capture, fills the store and
// issues one command per byte. Depends on aesx_pkg.
`timescale 1ns / 1ps

module aesx_front import aesx_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  output logic              push_valid,
  input  logic              push_ready,
  output cmd_t              push_cmd,
  output logic              ram_we,
  output logic [ADDR_W-1:0] ram_waddr,
  output logic [7:0]        ram_wdata,
  input  logic              emit_done
);

  logic             capturing_r, capturing_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             accept;
  logic             room;
  logic [CNT_W-1:0] cnt_stored;
  logic             is_letter;
  logic             seq_end;

  always_comb begin
    is_letter = ((in_byte >= LOWER_A) && (in_byte <= LOWER_Z)) ||
                ((in_byte >= UPPER_A) && (in_byte <= UPPER_N)) ||
                ((in_byte >= UPPER_P) && (in_byte <= UPPER_Z));
  end

  // Hold input while the back end still reads the store for an emission
  assign in_ready   = push_ready && !busy_r;
  assign accept     = in_valid && in_ready;
  assign push_valid = in_valid && !busy_r;

  assign room       = (cnt_r < CNT_W'(MAX_SEQUENCE));
  assign cnt_stored = room ? cnt_r + CNT_W'(1) : cnt_r;
  assign seq_end    = is_letter || (cnt_stored >= CNT_W'(MAX_SEQUENCE)) ||
                      ((cnt_stored == CNT_W'(2)) && (in_byte != CSI_BRACKET));

  assign ram_wdata = in_byte;

  always_comb begin
    capturing_nxt = capturing_r;
    cnt_nxt       = cnt_r;
    busy_nxt      = busy_r && !emit_done;
    ram_we        = 1'b0;
    ram_waddr     = cnt_r[ADDR_W-1:0];
    push_cmd.kind = ST_NOT_ESC;
    push_cmd.len  = '0;
    if (!capturing_r) begin
      if (in_byte == ESC_BYTE) begin
        push_cmd.kind = ST_CONTINUE;
        ram_waddr     = '0;
        ram_we        = accept;
        if (accept) begin
          capturing_nxt = 1'b1;
          cnt_nxt       = CNT_W'(1);
        end
      end
    end else begin
      ram_we = accept && room;
      if (seq_end) begin
        push_cmd.kind = ST_EMIT;
        push_cmd.len  = cnt_stored;
        if (accept) begin
          capturing_nxt = 1'b0;
          cnt_nxt       = '0;
          busy_nxt      = 1'b1;
        end
      end else begin
        push_cmd.kind = ST_CONTINUE;
        if (accept) begin
          cnt_nxt = cnt_stored;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capturing_r <= 1'b0;
      cnt_r       <= '0;
      busy_r      <= 1'b0;
    end else begin
      capturing_r <= capturing_nxt;
      cnt_r       <= cnt_nxt;
      busy_r      <= busy_nxt;
    end
  end

endmodule

@@ hw/rtl/aesx_cmd_fifo.sv @@
// Short command queue between the front and back ends.
// Depends on aesx_pkg for the command type and depth.
`timescale 1ns / 1ps

module aesx_cmd_fifo import aesx_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int LVL_W = $clog2(FIFO_DEPTH + 1);

  cmd_t             slots_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [LVL_W-1:0] level_r, level_nxt;
  logic             do_push, do_pop;

  assign push_ready = (level_r != LVL_W'(FIFO_DEPTH));
  assign pop_valid  = (level_r != '0);
  assign pop_cmd    = slots_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    level_nxt  = level_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      level_nxt = level_r + LVL_W'(1);
    end else if (do_pop && !do_push) begin
      level_nxt = level_r - LVL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

endmodule

@@ hw/rtl/aesx_back.sv @@
// Back end: executes queued commands, reads the store for emissions and
// drives the result register. Depends on aesx_pkg.
`timescale 1ns / 1ps

module aesx_back import aesx_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 pop_valid,
  output logic                 pop_ready,
  input  cmd_t                 pop_cmd,
  output logic                 ram_re,
  output logic [ADDR_W-1:0]    ram_raddr,
  input  logic [7:0]           ram_rdata,
  output logic                 emit_done,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_status,
  output logic [7:0]           out_byte,
  output logic [SEQ_LEN_W-1:0] out_seq_length,
  output logic                 out_last
);

  back_state_t          state_r, state_nxt;
  logic [ADDR_W-1:0]    idx_r, idx_nxt;
  logic [CNT_W-1:0]     len_r, len_nxt;
  logic                 out_valid_r, out_valid_nxt;
  status_t              out_status_r, out_status_nxt;
  logic [7:0]           out_byte_r, out_byte_nxt;
  logic [SEQ_LEN_W-1:0] out_len_r, out_len_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 slot_free;
  logic                 final_byte;
  logic                 load_single;
  logic                 load_emit;

  assign slot_free  = !out_valid_r || out_ready;
  assign final_byte = ((CNT_W'(idx_r) + CNT_W'(1)) == len_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (pop_valid && slot_free && (pop_cmd.kind == ST_EMIT)) begin
          state_nxt = BK_FETCH;
        end
      end
      BK_FETCH: state_nxt = BK_LOAD;
      BK_LOAD: begin
        if (slot_free) begin
          state_nxt = final_byte ? BK_IDLE : BK_FETCH;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    pop_ready   = 1'b0;
    ram_re      = 1'b0;
    load_single = 1'b0;
    load_emit   = 1'b0;
    emit_done   = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        pop_ready   = slot_free;
        load_single = pop_valid && slot_free && (pop_cmd.kind != ST_EMIT);
      end
      BK_FETCH: ram_re = 1'b1;
      BK_LOAD: begin
        load_emit = slot_free;
        emit_done = slot_free && final_byte;
      end
      default: ;
    endcase
  end

  assign ram_raddr = idx_r;

  always_comb begin
    idx_nxt        = idx_r;
    len_nxt        = len_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_byte_nxt   = out_byte_r;
    out_len_nxt    = out_len_r;
    out_last_nxt   = out_last_r;
    if ((state_r == BK_IDLE) && pop_valid && slot_free) begin
      idx_nxt = '0;
      len_nxt = pop_cmd.len;
    end
    if (load_single) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = pop_cmd.kind;
      out_byte_nxt   = '0;
      out_len_nxt    = '0;
      out_last_nxt   = 1'b1;
    end else if (load_emit) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = ST_EMIT;
      out_byte_nxt   = ram_rdata;
      out_len_nxt    = SEQ_LEN_W'(len_r);
      out_last_nxt   = final_byte;
      idx_nxt        = idx_r + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    len_r        <= len_nxt;
    out_status_r <= out_status_nxt;
    out_byte_r   <= out_byte_nxt;
    out_len_r    <= out_len_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_byte       = out_byte_r;
  assign out_seq_length = out_len_r;
  assign out_last       = out_last_r;

endmodule

@@ hw/rtl/aesx_checker.sv @@
// Port-level checks for ansi_escape_sequence_extractor_unit, with the bind.
// Depends on aesx_pkg and the top level's port list.
`timescale 1ns / 1ps

module aesx_checker import aesx_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [1:0]           out_status,
  input logic [7:0]           out_byte,
  input logic [SEQ_LEN_W-1:0] out_seq_length,
  input logic                 out_last
);

  // No result survives a reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_CONTINUE || out_status == ST_EMIT ||
                   out_status == ST_NOT_ESC))
    else $error("unknown status code");

  // Single results carry no byte, no length and always close the transaction
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_EMIT |->
      out_last && out_byte == '0 && out_seq_length == '0)
    else $error("malformed single result");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_status) && $stable(out_byte) &&
      $stable(out_seq_length) && $stable(out_last))
    else $error("result changed while stalled");

endmodule

bind ansi_escape_sequence_extractor_unit aesx_checker u_aesx_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_status     (out_status),
  .out_byte       (out_byte),
  .out_seq_length (out_seq_length),
  .out_last       (out_last)
);

@@ dv/ansi_escape_sequence_extractor_unit_tb.sv @@
// Self-checking testbench for the ANSI escape sequence extractor.
// Depends on aesx_pkg and ansi_escape_sequence_extractor_unit; needs nothing else.
`timescale 1ns / 1ps

module ansi_escape_sequence_extractor_unit_tb;
  import aesx_pkg::*;

  localparam int RANDOM_BYTES = 450;
  localparam int LONG_HOLD    = 300;
  localparam int SETTLE       = 40;
  localparam int PRINT_CAP    = 40;
  localparam int DIRECTED_N   = 24;

  typedef struct packed {
    status_t     status;
    logic [7:0]  data;
    logic [4:0]  len;
    logic        last;
  } esc_result_t;

  typedef struct packed {
    logic [7:0] data;
    logic       typed;
    status_t    status;
  } stim_row_t;

  typedef struct packed {
    logic        typed;
    esc_result_t res;
  } row_note_t;

  logic                 clk            = 1'b0;
  logic                 rst_n          = 1'b0;
  logic                 in_valid       = 1'b0;
  logic                 in_ready;
  logic [7:0]           in_byte        = 8'h00;
  logic                 out_valid;
  logic                 out_ready      = 1'b0;
  logic [1:0]           out_status;
  logic [7:0]           out_byte;
  logic [SEQ_LEN_W-1:0] out_seq_length;
  logic                 out_last;

  // Scanner state mirrored from the block
  logic       scan_capturing = 1'b0;
  int         scan_count     = 0;
  logic [7:0] scan_store [MAX_SEQUENCE];

  esc_result_t step_results[$];
  esc_result_t expected_results[$];
  row_note_t   row_notes[$];

  int mismatches     = 0;
  int bytes_sent     = 0;
  int seqs_emitted   = 0;
  int longest_seq    = 0;
  int not_esc_seen   = 0;
  int send_idle_pct  = 31;
  int recv_idle_pct  = 81;
  int hold_requests  = 0;

  // ESC '[' ... with plain, capped-by-letter and broken openings
  stim_row_t directed_rows [0:DIRECTED_N-1] = '{
    '{8'h00, 1'b1, ST_NOT_ESC},  '{8'hFF, 1'b1, ST_NOT_ESC},
    '{8'h41, 1'b1, ST_NOT_ESC},  '{8'h1B, 1'b1, ST_CONTINUE},
    '{8'h5B, 1'b1, ST_CONTINUE}, '{8'h31, 1'b1, ST_CONTINUE},
    '{8'h6D, 1'b0, ST_EMIT},     '{8'h1B, 1'b1, ST_CONTINUE},
    '{8'h58, 1'b0, ST_EMIT},     '{8'h1B, 1'b1, ST_CONTINUE},
    '{8'h28, 1'b0, ST_EMIT},     '{8'h1B, 1'b1, ST_CONTINUE},
    '{8'h5B, 1'b1, ST_CONTINUE}, '{8'h4F, 1'b1, ST_CONTINUE},
    '{8'h80, 1'b1, ST_CONTINUE}, '{8'hFF, 1'b1, ST_CONTINUE},
    '{8'h1B, 1'b1, ST_CONTINUE}, '{8'h40, 1'b1, ST_CONTINUE},
    '{8'h60, 1'b1, ST_CONTINUE}, '{8'h7B, 1'b1, ST_CONTINUE},
    '{8'h5A, 1'b0, ST_EMIT},     '{8'h1B, 1'b1, ST_CONTINUE},
    '{8'h5B, 1'b1, ST_CONTINUE}, '{8'h7A, 1'b0, ST_EMIT}
  };

  ansi_escape_sequence_extractor_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_byte       (out_byte),
    .out_seq_length (out_seq_length),
    .out_last       (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic bit closes_on_letter(input logic [7:0] b);
    return (b >= LOWER_A && b <= LOWER_Z) || (b >= UPPER_A && b <= UPPER_N) ||
           (b >= UPPER_P && b <= UPPER_Z);
  endfunction

  function automatic esc_result_t pack_result(input status_t s, input logic [7:0] d,
                                              input logic [4:0] n, input logic l);
    esc_result_t r;
    r.status = s;
    r.data   = d;
    r.len    = n;
    r.last   = l;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_CAP)
      $display("%0t ns: MISMATCH %s", $time, msg);
    mismatches++;
  endtask

  // Work out the results one accepted byte causes and advance the scanner
  task automatic scan_byte(input logic [7:0] b);
    int n;
    step_results.delete();
    if (!scan_capturing) begin
      if (b == ESC_BYTE) begin
        scan_capturing = 1'b1;
        scan_store[0]  = b;
        scan_count     = 1;
        step_results.push_back(pack_result(ST_CONTINUE, 8'h00, 5'd0, 1'b1));
      end else begin
        step_results.push_back(pack_result(ST_NOT_ESC, 8'h00, 5'd0, 1'b1));
      end
      return;
    end
    if (scan_count < MAX_SEQUENCE) begin
      scan_store[scan_count] = b;
      scan_count++;
    end
    n = scan_count;
    if (closes_on_letter(b) || n >= MAX_SEQUENCE || (n == 2 && b != CSI_BRACKET)) begin
      for (int k = 0; k < n; k++)
        step_results.push_back(pack_result(ST_EMIT, scan_store[k], n[4:0], k == n - 1));
      scan_capturing = 1'b0;
      scan_count     = 0;
    end else begin
      step_results.push_back(pack_result(ST_CONTINUE, 8'h00, 5'd0, 1'b1));
    end
  endtask

  // Predict on accepted input first, then check accepted output, in one place
  always @(posedge clk) begin : watch
    row_note_t   note;
    esc_result_t got;
    esc_result_t want;
    if (rst_n && in_valid && in_ready) begin
      scan_byte(in_byte);
      note = row_notes.pop_front();
      if (note.typed)
        expected_results.push_back(note.res);
      else
        foreach (step_results[i]) expected_results.push_back(step_results[i]);
    end
    if (rst_n && out_valid && out_ready) begin
      got = pack_result(status_t'(out_status), out_byte, out_seq_length, out_last);
      if (got.status == ST_NOT_ESC) not_esc_seen++;
      if (got.status == ST_EMIT && got.last) begin
        seqs_emitted++;
        if (got.len > longest_seq) longest_seq = int'(got.len);
      end
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: status %0d byte %02h",
                                  got.status, got.data));
      end else begin
        want = expected_results.pop_front();
        if (got.status != want.status)
          report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
        if (got.data != want.data)
          report_mismatch($sformatf("byte got %02h want %02h", got.data, want.data));
        if (got.len != want.len)
          report_mismatch($sformatf("length got %0d want %0d", got.len, want.len));
        if (got.last != want.last)
          report_mismatch($sformatf("last got %0d want %0d", got.last, want.last));
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested
  initial begin : receiver
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Offer one byte and hold it until the transaction completes
  task automatic offer_byte(input logic [7:0] b, input logic typed, input status_t s);
    row_note_t note;
    note.typed = typed;
    note.res   = pack_result(s, 8'h00, 5'd0, 1'b1);
    row_notes.push_back(note);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic offer_random(input logic [7:0] b);
    offer_byte(b, 1'b0, ST_CONTINUE);
  endtask

  function automatic logic [7:0] pick_letter();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (!closes_on_letter(b));
    return b;
  endfunction

  function automatic logic [7:0] pick_body_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (closes_on_letter(b));
    return b;
  endfunction

  // ESC '[' body terminator; a full-length body ends on the store limit instead
  task automatic send_escape_run();
    int body;
    if ($urandom_range(0, 9) == 0)
      body = $urandom_range(0, 1) ? MAX_SEQUENCE - 2 : $urandom_range(7, MAX_SEQUENCE - 3);
    else
      body = $urandom_range(0, 6);
    offer_random(ESC_BYTE);
    offer_random(CSI_BRACKET);
    for (int k = 0; k < body; k++) offer_random(pick_body_byte());
    if (body < MAX_SEQUENCE - 2) offer_random(pick_letter());
  endtask

  initial begin : stimulus
    int start_count;
    int pick;
    int phase;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      offer_byte(directed_rows[i].data, directed_rows[i].typed, directed_rows[i].status);

    start_count = bytes_sent;
    phase = 0;
    while (bytes_sent - start_count < RANDOM_BYTES) begin
      if (phase == 0 && bytes_sent - start_count >= RANDOM_BYTES / 3) begin
        phase = 1;
        send_idle_pct = 81;
        recv_idle_pct = 31;
      end else if (phase == 1 && bytes_sent - start_count >= 2 * RANDOM_BYTES / 3) begin
        phase = 2;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // stall the receiver long enough for the block to back up its input
        hold_requests <= hold_requests + 1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_escape_run();
      end else if (pick < 85) begin
        offer_random(8'($urandom_range(0, 255)));
      end else begin
        offer_random(ESC_BYTE);
        offer_random(8'($urandom_range(0, 255)));
      end
    end
    in_valid <= 1'b0;

    while (expected_results.size() != 0 || row_notes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

    $display("Sent %0d bytes across three stall mixes and a long receiver hold-off.",
             bytes_sent);
    $display("Saw %0d complete sequences (longest %0d bytes), %0d non-escape bytes.",
             seqs_emitted, longest_seq, not_esc_seen);
    if (mismatches == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ ansi_escape_sequence_extractor_unit.f @@
hw/rtl/aesx_pkg.sv
hw/rtl/aesx_ram.sv
hw/rtl/aesx_front.sv
hw/rtl/aesx_cmd_fifo.sv
hw/rtl/aesx_back.sv
hw/rtl/ansi_escape_sequence_extractor_unit.sv
hw/rtl/aesx_checker.sv
dv/ansi_escape_sequence_extractor_unit_tb.sv
